// ----- src/elfrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_pkg
// Shared types and constants of the relocation patch unit: word layouts,
// relocation type codes, status and store width codes, patch constants.
// ----------------------------------------------------------------------------
package elfrp_pkg;

  // Relocation type codes, psABI numbering.
  localparam logic [7:0] R_NONE         = 8'd0;
  localparam logic [7:0] R_WDISP30      = 8'd7;
  localparam logic [7:0] R_WDISP22      = 8'd8;
  localparam logic [7:0] R_HI22         = 8'd9;
  localparam logic [7:0] R_LO10         = 8'd12;
  localparam logic [7:0] R_COPY         = 8'd19;
  localparam logic [7:0] R_GLOB_DAT     = 8'd20;
  localparam logic [7:0] R_JMP_SLOT     = 8'd21;
  localparam logic [7:0] R_RELATIVE     = 8'd22;
  localparam logic [7:0] R_64           = 8'd32;
  localparam logic [7:0] R_HH22         = 8'd34;
  localparam logic [7:0] R_HM10         = 8'd35;
  localparam logic [7:0] R_LM22         = 8'd36;
  localparam logic [7:0] R_WDISP19      = 8'd41;
  localparam logic [7:0] R_TLS_DTPMOD64 = 8'd75;
  localparam logic [7:0] R_TLS_DTPOFF64 = 8'd77;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNHANDLED = 2'd1;
  localparam logic [1:0] ST_FAR       = 2'd2;
  localparam logic [1:0] ST_COPY      = 2'd3;

  // Store widths.
  localparam logic [1:0] WW_NONE = 2'd0;
  localparam logic [1:0] WW_32   = 2'd1;
  localparam logic [1:0] WW_64   = 2'd2;

  // Configuration register indexes, taken from paddr bit 3.
  localparam logic CFG_LOAD_BASE = 1'b0;
  localparam logic CFG_OWN_MOD   = 1'b1;
  localparam int unsigned CFG_ADDR_W = 4;

  // Jump slot instruction words, from highest address down.
  localparam logic [31:0] JMP_W0 = 32'h9e10_0001;
  localparam logic [31:0] JMP_W1 = 32'h4000_0000;
  localparam logic [31:0] JMP_W2 = 32'h8210_000f;
  localparam logic [31:0] JMP_W3 = 32'h0100_0000;

  // Largest forward call offset after biasing by 2^31.
  localparam logic [63:0] JMP_REACH_MAX = 64'h0000_0000_ffff_fffc;
  localparam logic [63:0] JMP_REACH_BIAS = 64'h0000_0000_7fff_fff8;

  typedef struct packed {
    logic [7:0]         func;
    logic [63:0]        place_offset;
    logic signed [63:0] addend;
    logic [63:0]        symbol_value;
    logic               symbol_module_valid;
    logic [31:0]        symbol_module_id;
    logic [31:0]        old_word;
    logic               last_entry;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  write_width;
    logic [63:0] write_address;
    logic [63:0] write_data;
    logic        last;
    logic        table_end;
  } out_item_t;

  // What the sequencer needs to finish a jump slot after its first word.
  typedef struct packed {
    logic        go;
    logic [63:0] place;
    logic [31:0] jump_word;
    logic        table_end;
  } burst_t;

endpackage

// ----- src/elfrp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_cfg
// APB register file: load base at 0x0, own thread-local module id at 0x8.
// ----------------------------------------------------------------------------
module elfrp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [elfrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  output logic [63:0]                    load_base,
  output logic [31:0]                    own_module_id
);
  import elfrp_pkg::*;

  logic [63:0] load_base_r, load_base_nxt;
  logic [31:0] own_mod_r, own_mod_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    load_base_nxt = load_base_r;
    own_mod_nxt   = own_mod_r;
    if (wr_en) begin
      unique case (paddr[3])
        CFG_LOAD_BASE: load_base_nxt = pwdata;
        CFG_OWN_MOD:   own_mod_nxt   = pwdata[31:0];
        default: begin
          load_base_nxt = load_base_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      CFG_LOAD_BASE: prdata = load_base_r;
      CFG_OWN_MOD:   prdata = {32'b0, own_mod_r};
      default:       prdata = 64'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r <= 64'b0;
      own_mod_r   <= 32'b0;
    end else begin
      load_base_r <= load_base_nxt;
      own_mod_r   <= own_mod_nxt;
    end
  end

  assign load_base     = load_base_r;
  assign own_module_id = own_mod_r;

endmodule

// ----- src/elfrp_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_calc
// Decodes one registered relocation entry into its first result word and,
// for an in-reach jump slot, the data the sequencer needs for the rest.
// ----------------------------------------------------------------------------
module elfrp_calc (
  input  elfrp_pkg::in_item_t  item,
  input  logic [63:0]          place,
  input  logic [63:0]          load_base,
  input  logic [31:0]          own_module_id,
  output elfrp_pkg::out_item_t first,
  output elfrp_pkg::burst_t    burst
);
  import elfrp_pkg::*;

  logic [63:0] a_u;
  logic [63:0] sa;
  logic [31:0] dpc;
  logic [31:0] got;
  logic [63:0] off;
  logic [63:0] reach;
  logic        far;
  logic [31:0] old;

  always_comb begin
    a_u   = item.addend;
    old   = item.old_word;
    sa    = item.symbol_value + a_u;
    dpc   = sa[31:0] - place[31:0];
    got   = load_base[31:0] + a_u[31:0] - place[31:0];
    off   = item.symbol_value - place - 64'd8;
    // The call offset fits when off + 2^31 lies in [0, 0xfffffffc].
    reach = item.symbol_value - place + JMP_REACH_BIAS;
    far   = reach > JMP_REACH_MAX;

    first.status        = ST_OK;
    first.write_width   = WW_NONE;
    first.write_address = place;
    first.write_data    = 64'b0;
    first.last          = 1'b1;
    first.table_end     = item.last_entry;

    burst.go        = 1'b0;
    burst.place     = place;
    burst.jump_word = JMP_W1 | {2'b0, off[31:2]};
    burst.table_end = item.last_entry;

    unique case (item.func) inside
      R_NONE: begin
        first.status = ST_OK;
      end
      R_WDISP30: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {2'b0, dpc[31:2]}};
      end
      R_WDISP22: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {10'b0, dpc[23:2]}};
      end
      R_WDISP19: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {13'b0, dpc[20:2]}};
      end
      R_HI22: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {10'b0, got[31:10]}};
      end
      R_LO10: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {22'b0, got[9:0]}};
      end
      R_LM22: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {10'b0, sa[31:10]}};
      end
      R_HH22: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {10'b0, sa[63:42]}};
      end
      R_HM10: begin
        first.write_width = WW_32;
        first.write_data  = {32'b0, old | {22'b0, sa[41:32]}};
      end
      R_GLOB_DAT, R_64, R_TLS_DTPOFF64: begin
        first.write_width = WW_64;
        first.write_data  = sa;
      end
      R_RELATIVE: begin
        first.write_width = WW_64;
        first.write_data  = load_base + a_u;
      end
      R_TLS_DTPMOD64: begin
        first.write_width = WW_64;
        first.write_data  = item.symbol_module_valid ?
                            {32'b0, item.symbol_module_id} : {32'b0, own_module_id};
      end
      R_COPY: begin
        // Without a resolved symbol there is nothing to copy.
        if (item.symbol_module_valid) begin
          first.status     = ST_COPY;
          first.write_data = item.symbol_value;
        end
      end
      R_JMP_SLOT: begin
        if (far) begin
          first.status = ST_FAR;
        end else begin
          first.write_width   = WW_32;
          first.write_address = place + 64'd12;
          first.write_data    = {32'b0, JMP_W0};
          first.last          = 1'b0;
          first.table_end     = 1'b0;
          burst.go            = 1'b1;
        end
      end
      default: begin
        first.status = ST_UNHANDLED;
      end
    endcase
  end

endmodule

// ----- src/elfrp_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_seq
// Result register and jump slot sequencer. Presents one word per cycle and
// walks the three remaining jump slot words down to the place itself.
// ----------------------------------------------------------------------------
module elfrp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  elfrp_pkg::out_item_t first,
  input  elfrp_pkg::burst_t    burst,
  output logic                 hold,
  output logic                 out_strobe,
  output elfrp_pkg::out_item_t out_data
);
  import elfrp_pkg::*;

  logic        vld_r, vld_nxt;
  out_item_t   data_r, data_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [63:0] place_r, place_nxt;
  logic [31:0] jw_r, jw_nxt;
  logic        end_r, end_nxt;
  logic [1:0]  step;
  out_item_t   next_word;

  // Words still owed after the one on the output.
  assign hold = rem_r != 2'd0;
  assign step = rem_r - 2'd1;

  always_comb begin
    next_word.status        = ST_OK;
    next_word.write_width   = WW_32;
    next_word.write_address = place_r + {60'b0, step, 2'b00};
    next_word.last          = 1'b0;
    next_word.table_end     = 1'b0;
    case (rem_r)
      2'd3:    next_word.write_data = {32'b0, jw_r};
      2'd2:    next_word.write_data = {32'b0, JMP_W2};
      default: begin
        next_word.write_data = {32'b0, JMP_W3};
        next_word.last       = 1'b1;
        next_word.table_end  = end_r;
      end
    endcase
  end

  always_comb begin
    vld_nxt   = 1'b0;
    data_nxt  = data_r;
    rem_nxt   = rem_r;
    place_nxt = place_r;
    jw_nxt    = jw_r;
    end_nxt   = end_r;
    if (hold) begin
      vld_nxt  = 1'b1;
      data_nxt = next_word;
      rem_nxt  = step;
    end else if (load) begin
      vld_nxt   = 1'b1;
      data_nxt  = first;
      rem_nxt   = burst.go ? 2'd3 : 2'd0;
      place_nxt = burst.place;
      jw_nxt    = burst.jump_word;
      end_nxt   = burst.table_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    place_r <= place_nxt;
    jw_r    <= jw_nxt;
    end_r   <= end_nxt;
  end

  assign out_strobe = vld_r;
  assign out_data   = data_r;

endmodule

// ----- src/elf_reloc_patch_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_reloc_patch_unit_core
// Applies SPARC ELF64 RELA relocations: one entry in, its patch words out.
// ----------------------------------------------------------------------------
// The entry is registered in the entry stage; the first result word is then
// registered in the sequencer's result register once it owes no more words.
// Throughput: one entry per cycle while the sequencer owes no words; an
// in-reach jump slot holds the output sequencer while it walks its remaining
// words, and busy is high while the next entry waits behind it.
// Results cannot be stalled; each word shows for one cycle with out_strobe.
// Reset (rst_n low, synchronous) empties both stages and clears the config registers.
module elf_reloc_patch_unit_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  elfrp_pkg::in_item_t              in_data,
  output logic                             out_strobe,
  output elfrp_pkg::out_item_t             out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [elfrp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                      pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready
);
  import elfrp_pkg::*;

  logic        a_vld_r, a_vld_nxt;
  in_item_t    a_item_r, a_item_nxt;
  logic [63:0] a_place_r, a_place_nxt;
  logic        accept;
  logic        a_adv;
  logic        seq_hold;
  logic [63:0] load_base;
  logic [31:0] own_module_id;
  out_item_t   first;
  burst_t      burst;

  elfrp_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .load_base     (load_base),
    .own_module_id (own_module_id)
  );

  // The entry stage moves on whenever the sequencer owes no more words.
  assign a_adv  = a_vld_r && !seq_hold;
  assign busy   = a_vld_r && seq_hold;
  assign accept = start && !busy;

  always_comb begin
    a_vld_nxt   = a_vld_r;
    a_item_nxt  = a_item_r;
    a_place_nxt = a_place_r;
    if (accept) begin
      a_vld_nxt   = 1'b1;
      a_item_nxt  = in_data;
      a_place_nxt = load_base + in_data.place_offset;
    end else if (a_adv) begin
      a_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r  <= a_item_nxt;
    a_place_r <= a_place_nxt;
  end

  elfrp_calc u_calc (
    .item          (a_item_r),
    .place         (a_place_r),
    .load_base     (load_base),
    .own_module_id (own_module_id),
    .first         (first),
    .burst         (burst)
  );

  elfrp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (a_adv),
    .first      (first),
    .burst      (burst),
    .hold       (seq_hold),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ----- src/elfrp_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_chk
// Port-level checks of the relocation patch unit, bound to the top level.
// ----------------------------------------------------------------------------
module elfrp_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 busy,
  input logic                 out_strobe,
  input elfrp_pkg::out_item_t out_data
);
  import elfrp_pkg::*;

  // The unit only stalls entries while it is emitting a jump slot.
  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_strobe)
    else $error("busy without an output word");

  // Only jump slots give several words, each one word below the previous.
  a_slot_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |=>
      (out_strobe && out_data.write_width == WW_32 &&
       out_data.write_address == $past(out_data.write_address) - 64'd4))
    else $error("jump slot words out of sequence");

  // Errors and copy requests are single results with no store.
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != ST_OK) |->
      (out_data.last && out_data.write_width == WW_NONE))
    else $error("non-ok status on a store or multi-word result");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.write_width == WW_NONE && out_data.status != ST_COPY) |->
      (out_data.write_data == 64'b0))
    else $error("no-store result carries data");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.table_end) |-> out_data.last)
    else $error("table end flagged before the final word");

endmodule

bind elf_reloc_patch_unit_core elfrp_chk u_elfrp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
